// File: hw/rtl/wahr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wahr_pkg
// Shared types, widths and codes of the windowed average history ring.
// ----------------------------------------------------------------------------
package wahr_pkg;

    // History depth and the widths that follow from it
    localparam int HIST_DEPTH = 5760;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    // Fixed field widths
    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int LABEL_W    = 11;
    localparam int RIDX_W     = 13;
    localparam int AVG_W      = 24;
    localparam int VAL_W      = 16;
    localparam int TOTAL_W    = 13;
    localparam int SUM_W      = 40;
    localparam int WCNT_W     = 16;
    localparam int DVD_W      = SUM_W + 1;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int IDX_W      = ((CNT_W > RIDX_W) ? CNT_W : RIDX_W) + 1;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd15000;
    localparam logic [WCNT_W-1:0] SAMPLES_MAX    = 16'hFFFF;
    localparam logic [VAL_W-1:0]  VALUE_MAX      = 16'hFFFF;

    // Input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic                is_read;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now;
        logic [LABEL_W-1:0]  label;
        logic [RIDX_W-1:0]   ridx;
    } cmd_item_t;

    typedef struct packed {
        logic               point_stored;
        logic [AVG_W-1:0]   average_value;
        logic [VAL_W-1:0]   entry_value;
        logic [LABEL_W-1:0] entry_label;
        logic               entry_valid;
        logic [TOTAL_W-1:0] entry_total;
    } result_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [VAL_W-1:0]   value;
    } hist_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RESULT
    } back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/wahr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wahr_front
// Accepts input transfers, unpacks and classifies them, and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module wahr_front
    import wahr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    // sample_value[23:0], timestamp_ms[55:24], minute_of_day[66:56], read_index[79:67]
    input  wire logic [79:0] s_tdata,
    // command[0]
    input  wire logic      s_tuser,
    output logic           q_valid,
    output cmd_item_t      q_item,
    input  wire logic      q_pop
);

    cmd_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    cmd_item_t          in_item;
    logic               push;
    logic               pop;

    always_comb
    begin
        in_item.is_read = (s_tuser == CMD_READ);
        in_item.sample  = s_tdata[23:0];
        in_item.now     = s_tdata[55:24];
        in_item.label   = s_tdata[66:56];
        in_item.ridx    = s_tdata[79:67];
    end

    assign s_tready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/wahr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wahr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wahr_div
    import wahr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [WCNT_W-1:0] divisor,
    output logic                   done,
    output logic [DVD_W-1:0]       quotient
);

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [WCNT_W-1:0]    rem_reg, rem_next;
    logic [WCNT_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WCNT_W:0]      rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = ge ? WCNT_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[WCNT_W-1:0];
        dvd_next  = {dvd_reg[DVD_W-2:0], ge};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// File: hw/rtl/wahr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wahr_back
// Carries out queued commands: window accumulation, rounded average through
// the serial divider, history ring writes and reads, result register.
// ----------------------------------------------------------------------------
module wahr_back
    import wahr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [TIME_W-1:0] interval,
    input  wire logic              q_valid,
    input  wire cmd_item_t         q_item,
    output logic                   q_pop,
    output logic                   res_valid,
    output result_t                res,
    input  wire logic              res_ready
);

    back_state_t       state_reg, state_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    result_t           res_reg, res_next;
    cmd_item_t         item_reg, item_next;
    logic [IDX_W-1:0]  isum_reg, isum_next;

    hist_entry_t       mem [HIST_DEPTH];
    hist_entry_t       rd_data_reg;
    hist_entry_t       wr_data;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;

    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic              close;
    logic [ADDR_W-1:0] first;
    logic [IDX_W-1:0]  isum;
    logic              in_range;
    logic [CNT_W-1:0]  count_inc;
    logic [WCNT_W-1:0] divisor;
    logic [DVD_W-1:0]  dividend;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  quotient;
    logic [VAL_W-1:0]  clamped;

    wahr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign start_eff = (start_reg == '0) ? q_item.now : start_reg;
    assign elapsed   = q_item.now - start_eff;
    assign close     = (elapsed >= interval);
    assign first     = (count_reg == CNT_W'(HIST_DEPTH)) ? wp_reg : '0;
    assign isum      = IDX_W'(first) + IDX_W'(q_item.ridx);
    assign in_range  = (IDX_W'(q_item.ridx) < IDX_W'(count_reg));
    assign count_inc = (count_reg < CNT_W'(HIST_DEPTH)) ? count_reg + 1'b1 : count_reg;
    assign divisor   = (wcnt_reg == '0) ? WCNT_W'(1) : wcnt_reg;
    assign dividend  = {1'b0, sum_reg} + DVD_W'(divisor >> 1);
    assign clamped   = (quotient[DVD_W-1:VAL_W] != '0) ? VALUE_MAX : quotient[VAL_W-1:0];
    assign rd_addr   = (isum_reg >= IDX_W'(HIST_DEPTH)) ?
                       ADDR_W'(isum_reg - IDX_W'(HIST_DEPTH)) : ADDR_W'(isum_reg);
    assign wr_data   = '{label: item_reg.label, value: clamped};

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        wcnt_next  = wcnt_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        res_next   = res_reg;
        item_next  = item_reg;
        isum_next  = isum_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    res_next  = '0;
                    res_next.entry_total = TOTAL_W'(count_reg);
                    if (q_item.is_read)
                    begin
                        isum_next = isum;
                        state_next = in_range ? ST_RD_ADDR : ST_RESULT;
                    end
                    else
                    begin
                        start_next = start_eff;
                        // hold sum and count once the count has saturated
                        if (wcnt_reg != SAMPLES_MAX)
                        begin
                            sum_next  = sum_reg + SUM_W'(q_item.sample);
                            wcnt_next = wcnt_reg + 1'b1;
                        end
                        state_next = close ? ST_DIV_START : ST_RESULT;
                    end
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    wp_next    = (wp_reg == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    count_next = count_inc;
                    start_next = item_reg.now;
                    sum_next   = '0;
                    wcnt_next  = '0;
                    res_next.point_stored  = 1'b1;
                    res_next.average_value = quotient[AVG_W-1:0];
                    res_next.entry_value   = clamped;
                    res_next.entry_label   = item_reg.label;
                    res_next.entry_valid   = 1'b0;
                    res_next.entry_total   = TOTAL_W'(count_inc);
                    state_next = ST_RESULT;
                end
            end
            ST_RD_ADDR:
            begin
                mem_re     = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                res_next.entry_value = rd_data_reg.value;
                res_next.entry_label = rd_data_reg.label;
                res_next.entry_valid = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            sum_reg   <= '0;
            wcnt_reg  <= '0;
            wp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
            wcnt_reg  <= wcnt_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        item_reg <= item_next;
        isum_reg <= isum_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

endmodule
`default_nettype wire

// File: hw/rtl/windowed_average_history_ring_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_average_history_ring_top
// Boxcar average decimator that stores window averages in a history ring.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one command per transfer. tuser selects add-sample or
//   read-history; tdata carries sample, timestamp, label and read index.
//   Master stream (m_*): exactly one result per command, in command order.
//   Config channel (cfg_*): writes the window interval in ms; always ready.
//   Write it only while no command is in flight.
// Steps per command, one command at a time after it leaves the input queue:
//   sample that keeps the window open : accumulated into the window
//   sample that closes the window     : averaged by the bit-serial divider
//                                       (41 quotient bits, 1 per cycle), stored
//   history read                      : memory read is registered
// A two-entry input queue keeps accepting commands while a result waits on
// m_tready; when the receiver stalls, the result holds and the queue fills.
// Reset clears the window, the ring pointer and the entry count, and sets
// the interval to 15000 ms; the history memory is not cleared.
// ----------------------------------------------------------------------------
module windowed_average_history_ring_top
    import wahr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample_value[23:0], timestamp_ms[55:24], minute_of_day[66:56], read_index[79:67]
    input  wire logic [79:0] s_tdata,
    // command[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // average_value[23:0], entry_value[39:24], entry_label[50:40], entry_total[63:51]
    output logic [63:0]      m_tdata,
    // point_stored[0], entry_valid[1]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic [TIME_W-1:0] interval_reg;
    logic              q_valid;
    cmd_item_t         q_item;
    logic              q_pop;
    result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            interval_reg <= cfg_data;
        end
    end

    wahr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    wahr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .interval  (interval_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.entry_total, res.entry_label, res.entry_value, res.average_value};
    assign m_tuser = {res.entry_valid, res.point_stored};

endmodule
`default_nettype wire
